FILE: rtl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/lfuc_pkg.sv
package lfuc_pkg;

   // default sizing
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_COUNT_BITS = 16;

   // fixed field widths
   localparam int KEY_W     = 31;
   localparam int VAL_W     = 31;
   localparam int CAP_REG_W = 5;

   localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_UPDATE,
      ST_UPDATE_END
   } state_type;

   // scan unit control
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

FILE: rtl/lfu_cache_with_lru_tiebreak_core.sv
// LFU key/value cache with LRU tie-break. A request (get or put) is taken
// when start is high and busy is low; busy then stays high while the entry
// memory is swept one entry per cycle through its single read port: one
// sweep to find the key, a free slot and the victim, and for a hit or an
// insert a second sweep that rewrites ranks and counts. The second sweep
// is skipped when nothing changes (get miss, put miss at capacity zero).
// The response is a single-cycle rsp_valid strobe in the cycle busy falls;
// it cannot be held off, so the receiver must take it then. A new request
// may be issued in that same cycle. Valid marks clear at reset; no memory
// clearing pass runs.
module lfu_cache_with_lru_tiebreak_core import lfuc_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [KEY_W-1:0]     req_lookup_key,
   input  logic [VAL_W-1:0]     req_write_value,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [VAL_W-1:0]     rsp_read_value,
   output logic                 rsp_evicted,
   input  logic                 csr_we,
   input  logic [CAP_REG_W-1:0] csr_wdata
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NUM_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (NUM_W > CAP_REG_W) ? NUM_W : CAP_REG_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [SLOT_W-1:0]     rank;
   } entry_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic                  p_vld_ff;
   logic [SLOT_W-1:0]     p_idx_ff;
   entry_type             rdata_ff;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CAP_REG_W-1:0]  cap_ff;
   logic                  kind_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VAL_W-1:0]      wval_ff;
   logic                  touch_ff;
   logic                  evict_ff;
   logic [SLOT_W-1:0]     slot_u_ff;
   logic [SLOT_W-1:0]     rank_ref_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [VAL_W-1:0]      rsp_value_ff;
   logic                  rsp_evicted_ff;

   entry_type             mem [CAPACITY];

   scan_ctl_type          scan_ctl;
   logic                  issue;
   logic                  mem_we;
   entry_type             wdata;
   logic                  last_idx;

   logic                  match_found;
   logic [SLOT_W-1:0]     match_slot;
   logic [SLOT_W-1:0]     match_rank;
   logic [VAL_W-1:0]      match_value;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_slot;
   logic [SLOT_W-1:0]     vic_slot;
   logic [SLOT_W-1:0]     vic_rank;
   logic [NUM_W-1:0]      num_valid;

   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      cap_lim;
   logic                  full;
   logic                  do_touch;
   logic                  do_insert;
   logic                  do_evict;
   logic                  change;
   logic [SLOT_W-1:0]     ins_slot;

   // scan unit
   lfuc_scan_unit #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS),
      .SLOT_W     (SLOT_W),
      .NUM_W      (NUM_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .slot        (p_idx_ff),
      .entry_valid (valid_ff[p_idx_ff]),
      .entry_key   (rdata_ff.key),
      .entry_value (rdata_ff.value),
      .entry_count (rdata_ff.count),
      .entry_rank  (rdata_ff.rank),
      .req_key     (key_ff),
      .match_found (match_found),
      .match_slot  (match_slot),
      .match_rank  (match_rank),
      .match_value (match_value),
      .free_found  (free_found),
      .free_slot   (free_slot),
      .vic_slot    (vic_slot),
      .vic_rank    (vic_rank),
      .num_valid   (num_valid)
   );

   // decision after the search sweep
   always_comb begin
      cap_ext   = CMP_W'(cap_ff);
      cap_lim   = (cap_ext < CMP_W'(CAPACITY)) ? cap_ext : CMP_W'(CAPACITY);
      full      = CMP_W'(num_valid) >= cap_lim;
      do_touch  = match_found;
      do_insert = !match_found && (kind_ff == KIND_PUT) && (cap_ff != '0);
      do_evict  = do_insert && full;
      change    = do_touch || do_insert;
      if (do_evict && !(free_found && (free_slot < vic_slot))) begin
         ins_slot = vic_slot;
      end else begin
         ins_slot = free_slot;
      end
   end

   // valid marks: drop the victim, claim the insert slot
   always_comb begin
      valid_in = valid_ff;
      if (state_ff == ST_DECIDE && do_insert) begin
         if (do_evict) valid_in[vic_slot] = 1'b0;
         valid_in[ins_slot] = 1'b1;
      end
   end

   // next state
   assign last_idx = (idx_ff == LAST_SLOT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (start) state_in = ST_SCAN;
         ST_SCAN:       if (last_idx) state_in = ST_SCAN_END;
         ST_SCAN_END:   state_in = ST_DECIDE;
         ST_DECIDE:     state_in = change ? ST_UPDATE : ST_IDLE;
         ST_UPDATE:     if (last_idx) state_in = ST_UPDATE_END;
         ST_UPDATE_END: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      issue          = 1'b0;
      scan_ctl.clear = 1'b0;
      scan_ctl.step  = 1'b0;
      mem_we         = 1'b0;
      rsp_valid_in   = 1'b0;
      idx_in         = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_ctl.clear = start;
            idx_in         = '0;
         end
         ST_SCAN: begin
            issue         = 1'b1;
            scan_ctl.step = p_vld_ff;
            idx_in        = last_idx ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_SCAN_END: begin
            scan_ctl.step = p_vld_ff;
         end
         ST_DECIDE: begin
            rsp_valid_in = !change;
            idx_in       = '0;
         end
         ST_UPDATE: begin
            issue  = 1'b1;
            mem_we = p_vld_ff && (valid_ff[p_idx_ff] || (p_idx_ff == slot_u_ff));
            idx_in = last_idx ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_UPDATE_END: begin
            mem_we       = p_vld_ff && (valid_ff[p_idx_ff] || (p_idx_ff == slot_u_ff));
            rsp_valid_in = 1'b1;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // entry rewrite: bump/insert the chosen slot, age or shift the rest
   always_comb begin
      wdata = rdata_ff;
      if (p_idx_ff == slot_u_ff) begin
         wdata.rank = '0;
         if (touch_ff) begin
            if (kind_ff == KIND_PUT) wdata.value = wval_ff;
            if (rdata_ff.count != '1) wdata.count = rdata_ff.count + COUNT_BITS'(1);
         end else begin
            wdata.key   = key_ff;
            wdata.value = wval_ff;
            wdata.count = COUNT_BITS'(1);
         end
      end else if (touch_ff) begin
         if (rdata_ff.rank < rank_ref_ff) wdata.rank = rdata_ff.rank + SLOT_W'(1);
      end else if (!(evict_ff && (rdata_ff.rank > rank_ref_ff))) begin
         wdata.rank = rdata_ff.rank + SLOT_W'(1);
      end
   end

   // entry memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) mem[p_idx_ff] <= wdata;
      rdata_ff <= mem[idx_ff];
      p_idx_ff <= idx_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         p_vld_ff     <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) cap_ff <= csr_wdata;
         valid_ff     <= valid_in;
      end
   end

   // request and decision payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff <= req_kind;
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
      end
      if (state_ff == ST_DECIDE) begin
         touch_ff       <= do_touch;
         evict_ff       <= do_evict;
         slot_u_ff      <= do_touch ? match_slot : ins_slot;
         rank_ref_ff    <= do_touch ? match_rank : vic_rank;
         rsp_hit_ff     <= match_found;
         rsp_value_ff   <= (match_found && kind_ff == KIND_GET) ? match_value : '0;
         rsp_evicted_ff <= do_evict;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule

FILE: rtl/lfuc_scan_unit.sv
// Walks the entries one per step: key match, free slot, live count and
// the replacement victim (lowest count, oldest among equal counts).
module lfuc_scan_unit import lfuc_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int SLOT_W     = 4,
   parameter int NUM_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctl_type          ctl,
   input  logic [SLOT_W-1:0]     slot,
   input  logic                  entry_valid,
   input  logic [KEY_W-1:0]      entry_key,
   input  logic [VAL_W-1:0]      entry_value,
   input  logic [COUNT_BITS-1:0] entry_count,
   input  logic [SLOT_W-1:0]     entry_rank,
   input  logic [KEY_W-1:0]      req_key,
   output logic                  match_found,
   output logic [SLOT_W-1:0]     match_slot,
   output logic [SLOT_W-1:0]     match_rank,
   output logic [VAL_W-1:0]      match_value,
   output logic                  free_found,
   output logic [SLOT_W-1:0]     free_slot,
   output logic [SLOT_W-1:0]     vic_slot,
   output logic [SLOT_W-1:0]     vic_rank,
   output logic [NUM_W-1:0]      num_valid
);

   logic                  match_found_ff;
   logic [SLOT_W-1:0]     match_slot_ff;
   logic [SLOT_W-1:0]     match_rank_ff;
   logic [VAL_W-1:0]      match_value_ff;
   logic                  free_found_ff;
   logic [SLOT_W-1:0]     free_slot_ff;
   logic                  vic_found_ff;
   logic [SLOT_W-1:0]     vic_slot_ff;
   logic [SLOT_W-1:0]     vic_rank_ff;
   logic [COUNT_BITS-1:0] vic_count_ff;
   logic [NUM_W-1:0]      num_valid_ff;

   logic is_match;
   logic is_better;

   // shared compare unit
   always_comb begin
      is_match  = entry_valid && (entry_key == req_key) && !match_found_ff;
      is_better = entry_valid && (!vic_found_ff || (entry_count < vic_count_ff) ||
                  ((entry_count == vic_count_ff) && (entry_rank > vic_rank_ff)));
   end

   // trackers, flags cleared per request
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         vic_found_ff   <= 1'b0;
         num_valid_ff   <= '0;
      end else if (ctl.step) begin
         if (is_match) begin
            match_found_ff <= 1'b1;
            match_slot_ff  <= slot;
            match_rank_ff  <= entry_rank;
            match_value_ff <= entry_value;
         end
         if (!entry_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= slot;
         end
         if (is_better) begin
            vic_found_ff <= 1'b1;
            vic_slot_ff  <= slot;
            vic_rank_ff  <= entry_rank;
            vic_count_ff <= entry_count;
         end
         if (entry_valid) begin
            num_valid_ff <= num_valid_ff + NUM_W'(1);
         end
      end
   end

   assign match_found = match_found_ff;
   assign match_slot  = match_slot_ff;
   assign match_rank  = match_rank_ff;
   assign match_value = match_value_ff;
   assign free_found  = free_found_ff;
   assign free_slot   = free_slot_ff;
   assign vic_slot    = vic_slot_ff;
   assign vic_rank    = vic_rank_ff;
   assign num_valid   = num_valid_ff;

endmodule

FILE: rtl/lfuc_checker.sv
`include "assert_macros.svh"

// Port-level checks for the cache core.
module lfuc_checker import lfuc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_hit,
   input logic [VAL_W-1:0]     rsp_read_value,
   input logic                 rsp_evicted
);

   // a taken request keeps the core busy
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)

   // every completed request ends in a response strobe
   `ASSERT_SAME(a_done_rsp, clock, reset, !$past(reset) && $fell(busy), rsp_valid)

   // response shows only when the core is free
   `ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)

   // miss reads zero; eviction only on a miss
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_read_value == '0)
   `ASSERT_SAME(a_evict_miss, clock, reset, rsp_valid && rsp_evicted, !rsp_hit)

endmodule

bind lfu_cache_with_lru_tiebreak_core lfuc_checker u_lfuc_checker (.*);
